// File: rtl/gdlp_pkg.sv
package gdlp_pkg;
  localparam int GRID_BITS = 6;
  localparam int LEVEL_CAP = 63;
  localparam int MAX_BUDGET = 63;
  localparam int SIDE = 1 << GRID_BITS;
  localparam int CELLS = SIDE * SIDE;
  localparam int IDX_W = 2 * GRID_BITS;
  localparam int CNT_W = IDX_W + 1;
  localparam int LVL_W = 6;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_PROC = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_CHG = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] pos_x;
    logic [5:0] pos_z;
    logic [6:0] level;
    logic       lower_only;
    logic [5:0] budget;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cell_x;
    logic [5:0] cell_z;
    logic [5:0] old_level;
    logic [5:0] new_level;
    logic [5:0] source_level;
    logic [5:0] processed;
    logic       queue_empty;
    logic       last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0] cmd;
    logic       on_grid;
    logic [IDX_W-1:0] idx;
    logic [5:0] pos_x;
    logic [5:0] pos_z;
    logic [LVL_W-1:0] req;
    logic       lower_only;
    logic [5:0] limit;
  } job_t;
endpackage

// File: rtl/gdlp_if.sv
interface gdlp_in_if (input logic clk_i);
  import gdlp_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gdlp_out_if (input logic clk_i);
  import gdlp_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/grid_distance_level_propagator_unit.sv
// channel | dir | payload                                  | handshake
// in_i    | in  | cmd pos_x pos_z level lower_only budget   | valid/ready
// out_o   | out | kind cell_x cell_z levels processed flags | valid/ready
// set and query each answer with one word once the output is free; process
// handles popped cells one at a time, the work on each cell
// bound by the single read port of the level memory
// (nine reads, then up to eight pending-map checks and fifo writes)
// after reset and on clear, a sweep over all 4096 cells rewrites the level,
// source and pending-map memories; the back takes no job meanwhile
// a two-word queue lets the front take commands while the back works
module grid_distance_level_propagator_unit (
  input logic clk_i,
  input logic rst_ni,
  gdlp_in_if.sink    in_i,
  gdlp_out_if.source out_o
);
  import gdlp_pkg::*;
  job_t job;
  logic job_valid, job_ready;

  gdlp_front u_front (.clk_i, .rst_ni, .in_i, .job_o(job), .job_valid_o(job_valid),
    .job_ready_i(job_ready));
  gdlp_back u_back (.clk_i, .rst_ni, .job_i(job), .job_valid_i(job_valid),
    .job_ready_o(job_ready), .out_o);
endmodule

// File: rtl/gdlp_ram.sv
module gdlp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/gdlp_front.sv
module gdlp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  gdlp_in_if.sink          in_i,
  output gdlp_pkg::job_t   job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);
  import gdlp_pkg::*;

  // two-entry job queue
  job_t q_mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  job_t job_d;
  logic push, pop;

  always_comb begin
    job_d.cmd = in_i.data.cmd;
    job_d.on_grid = (int'(in_i.data.pos_x) < SIDE) && (int'(in_i.data.pos_z) < SIDE);
    job_d.idx = {in_i.data.pos_z[GRID_BITS-1:0], in_i.data.pos_x[GRID_BITS-1:0]};
    job_d.pos_x = in_i.data.pos_x;
    job_d.pos_z = in_i.data.pos_z;
    job_d.req = (int'(in_i.data.level) > LEVEL_CAP) ? LVL_W'(LEVEL_CAP)
                                                     : in_i.data.level[LVL_W-1:0];
    job_d.lower_only = in_i.data.lower_only;
    job_d.limit = (int'(in_i.data.budget) > MAX_BUDGET) ? 6'(MAX_BUDGET)
                                                         : in_i.data.budget;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign pop = job_valid_o && job_ready_i;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/gdlp_back.sv
module gdlp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gdlp_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  gdlp_out_if.source     out_o
);
  import gdlp_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SET_RD, S_SET_WR, S_Q_RD, S_POP, S_CUR,
    S_NB_RD, S_NB_ACC, S_DECIDE, S_ENQ_RD, S_ENQ_WR, S_EMIT, S_WAIT
  } state_e;

  state_e state_q, after_q;
  job_t job_q;
  logic [IDX_W-1:0] clr_q, head_q, tail_q, cidx_q, nidx_q;
  logic [CNT_W-1:0] cnt_q;
  logic [3:0] nb_q;
  logic [5:0] done_q;
  logic [LVL_W-1:0] cur_q, best_q, src_q;
  logic out_v_q;
  out_word_t out_q;
  logic nb_ok;
  logic [IDX_W-1:0] nb_idx;

  // level, source, pending map, fifo
  logic lv_we, sr_we, pm_we, wf_we;
  logic [IDX_W-1:0] lv_wa, lv_ra, sr_wa, sr_ra, pm_wa, pm_ra, wf_wa, wf_ra;
  logic [LVL_W-1:0] lv_wd, lv_rd, sr_wd, sr_rd;
  logic pm_wd, pm_rd;
  logic [IDX_W-1:0] wf_wd, wf_rd;

  gdlp_ram #(.Width(LVL_W), .Depth(CELLS)) u_lvl (.clk_i, .we_i(lv_we), .waddr_i(lv_wa),
    .wdata_i(lv_wd), .raddr_i(lv_ra), .rdata_o(lv_rd));
  gdlp_ram #(.Width(LVL_W), .Depth(CELLS)) u_src (.clk_i, .we_i(sr_we), .waddr_i(sr_wa),
    .wdata_i(sr_wd), .raddr_i(sr_ra), .rdata_o(sr_rd));
  gdlp_ram #(.Width(1), .Depth(CELLS)) u_pend (.clk_i, .we_i(pm_we), .waddr_i(pm_wa),
    .wdata_i(pm_wd), .raddr_i(pm_ra), .rdata_o(pm_rd));
  gdlp_ram #(.Width(IDX_W), .Depth(CELLS)) u_fifo (.clk_i, .we_i(wf_we), .waddr_i(wf_wa),
    .wdata_i(wf_wd), .raddr_i(wf_ra), .rdata_o(wf_rd));

  // neighbour nb_q (0..8, 4 is the centre) of the current cell
  always_comb begin
    logic [GRID_BITS:0] nx, nz;
    logic [1:0] dx, dz;
    dx = (nb_q inside {4'd0, 4'd3, 4'd6}) ? 2'd0 :
         (nb_q inside {4'd1, 4'd4, 4'd7}) ? 2'd1 : 2'd2;
    dz = (nb_q < 4'd3) ? 2'd0 : (nb_q < 4'd6) ? 2'd1 : 2'd2;
    nx = {1'b0, cidx_q[GRID_BITS-1:0]} + (GRID_BITS+1)'(dx) - (GRID_BITS+1)'(1);
    nz = {1'b0, cidx_q[IDX_W-1:GRID_BITS]} + (GRID_BITS+1)'(dz) - (GRID_BITS+1)'(1);
    nb_ok = (nb_q != 4'd4) && !nx[GRID_BITS] && !nz[GRID_BITS];
    nb_idx = {nz[GRID_BITS-1:0], nx[GRID_BITS-1:0]};
  end

  always_comb begin
    lv_we = 1'b0; sr_we = 1'b0; pm_we = 1'b0; wf_we = 1'b0;
    lv_wa = cidx_q; sr_wa = job_q.idx; pm_wa = cidx_q; wf_wa = tail_q;
    lv_wd = best_q; sr_wd = best_q; pm_wd = 1'b0; wf_wd = nidx_q;
    lv_ra = job_q.idx; sr_ra = job_q.idx; pm_ra = nidx_q; wf_ra = head_q;
    case (state_q)
      S_CLR: begin
        lv_we = 1'b1; sr_we = 1'b1; pm_we = 1'b1;
        lv_wa = clr_q; sr_wa = clr_q; pm_wa = clr_q;
        lv_wd = LVL_W'(LEVEL_CAP); sr_wd = LVL_W'(LEVEL_CAP);
      end
      S_IDLE: begin
        lv_ra = job_i.idx; sr_ra = job_i.idx;
      end
      S_SET_WR: begin
        sr_we = (best_q != src_q);
        pm_we = (best_q != src_q) && !pm_rd;
        pm_wa = job_q.idx; pm_wd = 1'b1;
        wf_we = pm_we; wf_wd = job_q.idx;
      end
      S_SET_RD: pm_ra = job_q.idx;
      S_CUR: begin
        lv_ra = wf_rd; sr_ra = wf_rd; pm_wa = wf_rd; pm_we = 1'b1;
      end
      S_NB_RD: lv_ra = nb_idx;
      S_DECIDE: lv_we = (best_q != cur_q);
      S_ENQ_RD: pm_ra = nb_idx;
      S_ENQ_WR: begin
        pm_we = !pm_rd; pm_wa = nidx_q; pm_wd = 1'b1;
        wf_we = !pm_rd;
      end
      default: ;
    endcase
  end

  assign job_ready_o = (state_q == S_IDLE) && !out_v_q;
  assign out_o.valid = out_v_q;
  assign out_o.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [LVL_W:0] prop;
    if (!rst_ni) begin
      state_q <= S_CLR; after_q <= S_IDLE;
      clr_q <= '0; head_q <= '0; tail_q <= '0; cnt_q <= '0;
      nb_q <= '0; done_q <= '0; out_v_q <= 1'b0;
      job_q <= '0; cidx_q <= '0; nidx_q <= '0;
      cur_q <= '0; best_q <= '0; src_q <= '0; out_q <= '0;
    end else begin
      if (out_o.valid && out_o.ready) out_v_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= after_q;
        end
        S_IDLE: if (job_valid_i && !out_v_q) begin
          job_q <= job_i;
          done_q <= '0;
          case (job_i.cmd)
            CMD_SET: state_q <= S_SET_RD;
            CMD_QUERY: state_q <= S_Q_RD;
            CMD_CLEAR: begin
              head_q <= '0; tail_q <= '0; cnt_q <= '0;
              out_q <= '{kind: KIND_ACK, queue_empty: 1'b1, last: 1'b1, default: '0};
              after_q <= S_WAIT; state_q <= S_CLR;
            end
            default: state_q <= S_POP;
          endcase
        end
        S_SET_RD: begin
          nidx_q <= job_q.idx;
          state_q <= S_SET_WR;
          src_q <= sr_rd;
          best_q <= (job_q.lower_only && sr_rd < job_q.req) ? sr_rd : job_q.req;
          if (!job_q.on_grid) begin
            out_q <= '{kind: KIND_ACK, cell_x: job_q.pos_x, cell_z: job_q.pos_z,
                       old_level: 6'(LEVEL_CAP), new_level: 6'(LEVEL_CAP),
                       source_level: 6'(LEVEL_CAP), processed: 6'd0,
                       queue_empty: (cnt_q == '0), last: 1'b1};
            state_q <= S_EMIT;
          end
        end
        S_SET_WR: begin
          if ((best_q != src_q) && !pm_rd) begin
            tail_q <= tail_q + 1'b1; cnt_q <= cnt_q + 1'b1;
          end
          out_q <= '{kind: KIND_ACK, cell_x: job_q.pos_x, cell_z: job_q.pos_z,
                     old_level: 6'(src_q), new_level: 6'(best_q), source_level: 6'(best_q),
                     processed: 6'd0,
                     queue_empty: (cnt_q == '0) && !((best_q != src_q) && !pm_rd),
                     last: 1'b1};
          state_q <= S_EMIT;
        end
        S_Q_RD: begin
          out_q <= '{kind: KIND_QUERY, cell_x: job_q.pos_x, cell_z: job_q.pos_z,
                     old_level: 6'd0,
                     new_level: job_q.on_grid ? 6'(lv_rd) : 6'(LEVEL_CAP),
                     source_level: job_q.on_grid ? 6'(sr_rd) : 6'(LEVEL_CAP),
                     processed: 6'd0, queue_empty: (cnt_q == '0), last: 1'b1};
          state_q <= S_EMIT;
        end
        S_POP: begin
          if (cnt_q == '0 || done_q >= job_q.limit) begin
            out_q <= '{kind: KIND_DONE, processed: done_q,
                       queue_empty: (cnt_q == '0), last: 1'b1, default: '0};
            state_q <= S_EMIT;
          end else state_q <= S_CUR;
        end
        S_CUR: begin
          // fifo word arrives now; its pending bit is cleared by the comb path
          cidx_q <= wf_rd;
          head_q <= head_q + 1'b1; cnt_q <= cnt_q - 1'b1;
          done_q <= done_q + 1'b1;
          nb_q <= '0;
          state_q <= S_NB_RD;
        end
        S_NB_RD: begin
          if (nb_q == 4'd0) begin
            cur_q <= lv_rd; best_q <= sr_rd; src_q <= sr_rd;
          end
          state_q <= nb_ok ? S_NB_ACC : S_NB_RD;
          if (!nb_ok) begin
            if (nb_q == 4'd8) state_q <= S_DECIDE; else nb_q <= nb_q + 1'b1;
          end
        end
        S_NB_ACC: begin
          prop = (int'(lv_rd) >= LEVEL_CAP) ? (LVL_W+1)'(LEVEL_CAP)
                                              : {1'b0, lv_rd} + 1'b1;
          if (prop < {1'b0, best_q}) best_q <= prop[LVL_W-1:0];
          if (nb_q == 4'd8) state_q <= S_DECIDE;
          else begin
            nb_q <= nb_q + 1'b1; state_q <= S_NB_RD;
          end
        end
        S_DECIDE: begin
          nb_q <= '0;
          if (best_q == cur_q) state_q <= S_POP;
          else state_q <= S_ENQ_RD;
        end
        S_ENQ_RD: begin
          if (nb_q == 4'd9) begin
            out_q <= '{kind: KIND_CHG, cell_x: 6'(cidx_q[GRID_BITS-1:0]),
                       cell_z: 6'(cidx_q[IDX_W-1:GRID_BITS]), old_level: 6'(cur_q),
                       new_level: 6'(best_q), source_level: 6'(src_q),
                       processed: done_q, queue_empty: (cnt_q == '0), last: 1'b0};
            after_q <= S_POP; state_q <= S_WAIT;
            out_v_q <= 1'b1;
          end else if (nb_ok) begin
            nidx_q <= nb_idx; state_q <= S_ENQ_WR;
          end else nb_q <= nb_q + 1'b1;
        end
        S_ENQ_WR: begin
          // pending bit of nidx_q was addressed in ENQ_RD
          state_q <= S_ENQ_RD;
          if (!pm_rd) begin
            tail_q <= tail_q + 1'b1; cnt_q <= cnt_q + 1'b1;
          end
          nb_q <= nb_q + 1'b1;
        end
        S_EMIT: begin
          out_v_q <= 1'b1; after_q <= S_IDLE; state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (after_q == S_WAIT) begin
            out_v_q <= 1'b1; after_q <= S_IDLE;
          end else if (!out_v_q || (out_o.valid && out_o.ready)) state_q <= after_q;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sim/grid_distance_level_propagator_unit_tb.sv
`timescale 1ns / 1ps

module grid_distance_level_propagator_unit_tb;
  import gdlp_pkg::*;

  localparam int N_RANDOM   = 300;
  localparam int IDLE_LIMIT = 30000;
  localparam int HOLD_LEN   = 700;    // long receiver hold-off
  localparam int DRAIN_WAIT = 200;

  logic clk_i;
  logic rst_ni;

  gdlp_in_if  in_if  (clk_i);
  gdlp_out_if out_if (clk_i);

  grid_distance_level_propagator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // shadow of the grid state
  logic [LVL_W-1:0] dist_map [CELLS];
  logic [LVL_W-1:0] src_map  [CELLS];
  bit               queued   [CELLS];
  int               work_q   [$];

  out_word_t expected_q [$];
  int        errors;
  int        words_sent;
  int        quiet_cycles;
  bit        calm;      // window with no idling on either side
  bit        hold_go;   // asks the receiver for one long hold-off
  bit        stim_done;

  // directed table
  typedef struct {
    in_word_t  word;
    bit        typed;   // expected result given below instead of predicted
    out_word_t exp;
  } row_t;
  row_t table_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, out_word_t got, out_word_t exp);
    errors++;
    $display("mismatch %s: got %p expected %p", what, got, exp);
  endtask

  function automatic in_word_t mk_in(logic [1:0] cmd, int x, int z, int lvl, bit lo,
                                     int bud);
    in_word_t w;
    w.cmd = cmd;
    w.pos_x = x[5:0];
    w.pos_z = z[5:0];
    w.level = lvl[6:0];
    w.lower_only = lo;
    w.budget = bud[5:0];
    return w;
  endfunction

  function automatic out_word_t mk_out(logic [1:0] kind, int x, int z, int ol, int nl,
                                       int sl, int pr, bit qe, bit last);
    out_word_t r;
    r.kind = kind;
    r.cell_x = x[5:0];
    r.cell_z = z[5:0];
    r.old_level = ol[5:0];
    r.new_level = nl[5:0];
    r.source_level = sl[5:0];
    r.processed = pr[5:0];
    r.queue_empty = qe;
    r.last = last;
    return r;
  endfunction

  function automatic void wipe_grid();
    for (int i = 0; i < CELLS; i++) begin
      dist_map[i] = LVL_W'(LEVEL_CAP);
      src_map[i] = LVL_W'(LEVEL_CAP);
      queued[i] = 1'b0;
    end
    work_q.delete();
  endfunction

  function automatic void push_cell(int idx);
    if (queued[idx]) return;
    queued[idx] = 1'b1;
    work_q.push_back(idx);
  endfunction

  // works out the words one command produces and updates the shadow grid
  function automatic void propagate(in_word_t w, ref out_word_t res[$]);
    int idx, req, prev, nxt, lim, done, x, z, cur, best, nx, nz, nl, prop;
    res.delete();
    idx = (int'(w.pos_z) << GRID_BITS) | int'(w.pos_x);
    case (w.cmd)
      CMD_SET: begin
        req = (w.level > LEVEL_CAP) ? LEVEL_CAP : int'(w.level);
        prev = src_map[idx];
        nxt = (w.lower_only && prev < req) ? prev : req;
        if (nxt != prev) begin
          src_map[idx] = nxt[LVL_W-1:0];
          push_cell(idx);
        end
        res.push_back(mk_out(KIND_ACK, w.pos_x, w.pos_z, prev, nxt, nxt, 0,
                             work_q.size() == 0, 1'b1));
      end
      CMD_PROC: begin
        lim = (w.budget > MAX_BUDGET) ? MAX_BUDGET : int'(w.budget);
        done = 0;
        while (work_q.size() > 0 && done < lim) begin
          idx = work_q.pop_front();
          queued[idx] = 1'b0;
          done++;
          x = idx % SIDE;
          z = idx / SIDE;
          cur = dist_map[idx];
          best = src_map[idx];
          for (int dz = -1; dz <= 1; dz++)
            for (int dx = -1; dx <= 1; dx++) begin
              nx = x + dx;
              nz = z + dz;
              if ((dx == 0 && dz == 0) || nx < 0 || nz < 0 || nx >= SIDE || nz >= SIDE)
                continue;
              nl = dist_map[nz * SIDE + nx];
              prop = (nl >= LEVEL_CAP) ? LEVEL_CAP : nl + 1;
              if (prop < best) best = prop;
            end
          if (best > LEVEL_CAP) best = LEVEL_CAP;
          if (best == cur) continue;
          dist_map[idx] = best[LVL_W-1:0];
          for (int dz = -1; dz <= 1; dz++)
            for (int dx = -1; dx <= 1; dx++) begin
              nx = x + dx;
              nz = z + dz;
              if ((dx == 0 && dz == 0) || nx < 0 || nz < 0 || nx >= SIDE || nz >= SIDE)
                continue;
              push_cell(nz * SIDE + nx);
            end
          res.push_back(mk_out(KIND_CHG, x, z, cur, best, src_map[idx], done,
                               work_q.size() == 0, 1'b0));
        end
        res.push_back(mk_out(KIND_DONE, 0, 0, 0, 0, 0, done, work_q.size() == 0, 1'b1));
      end
      CMD_CLEAR: begin
        wipe_grid();
        res.push_back(mk_out(KIND_ACK, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
      end
      default: begin
        res.push_back(mk_out(KIND_QUERY, w.pos_x, w.pos_z, 0, dist_map[idx], src_map[idx],
                             0, work_q.size() == 0, 1'b1));
      end
    endcase
  endfunction

  function automatic void add_row(in_word_t w, bit typed = 1'b0,
                                  out_word_t e = '0);
    row_t r;
    r.word = w;
    r.typed = typed;
    r.exp = e;
    table_rows.push_back(r);
  endfunction

  // directed rows: extremes, every command, corners and off-grid neighbours
  function automatic void build_table();
    // fresh grid reads back the maximum everywhere
    add_row(mk_in(CMD_QUERY, 0, 0, 0, 0, 0), 1,
            mk_out(KIND_QUERY, 0, 0, 0, LEVEL_CAP, LEVEL_CAP, 0, 1, 1));
    add_row(mk_in(CMD_QUERY, 63, 63, 127, 1, 63), 1,
            mk_out(KIND_QUERY, 63, 63, 0, LEVEL_CAP, LEVEL_CAP, 0, 1, 1));
    // level above maximum saturates, no change, nothing queued
    add_row(mk_in(CMD_SET, 0, 0, 127, 0, 63), 1,
            mk_out(KIND_ACK, 0, 0, LEVEL_CAP, LEVEL_CAP, LEVEL_CAP, 0, 1, 1));
    // empty queue: process pops nothing
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 63), 1,
            mk_out(KIND_DONE, 0, 0, 0, 0, 0, 0, 1, 1));
    add_row(mk_in(CMD_SET, 0, 0, 0, 0, 0), 1,
            mk_out(KIND_ACK, 0, 0, LEVEL_CAP, 0, 0, 0, 0, 1));
    // zero budget leaves the queue alone
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 0), 1,
            mk_out(KIND_DONE, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk_in(CMD_SET, 63, 63, 1, 0, 0));
    add_row(mk_in(CMD_SET, 63, 0, 2, 0, 0));
    add_row(mk_in(CMD_SET, 0, 63, 3, 1, 0));
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 1));
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 63));
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 42));
    // lower-only keeps the smaller source
    add_row(mk_in(CMD_SET, 63, 63, 40, 1, 0));
    add_row(mk_in(CMD_SET, 63, 0, 0, 1, 0));
    // raising a source without lower-only
    add_row(mk_in(CMD_SET, 0, 0, 62, 0, 21));
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 63));
    add_row(mk_in(CMD_QUERY, 1, 1, 0, 0, 0));
    add_row(mk_in(CMD_QUERY, 62, 62, 0, 0, 0));
    // removing a source by writing the maximum
    add_row(mk_in(CMD_SET, 63, 0, 63, 0, 0));
    add_row(mk_in(CMD_PROC, 0, 0, 0, 0, 63));
    add_row(mk_in(CMD_CLEAR, 21, 42, 85, 1, 42), 1,
            mk_out(KIND_ACK, 0, 0, 0, 0, 0, 0, 1, 1));
    add_row(mk_in(CMD_QUERY, 0, 63, 0, 0, 0), 1,
            mk_out(KIND_QUERY, 0, 63, 0, LEVEL_CAP, LEVEL_CAP, 0, 1, 1));
  endfunction

  // random command, mostly clustered so that propagation runs deep
  function automatic in_word_t rand_word();
    int r, x, z, lvl;
    r = $urandom_range(99);
    if ($urandom_range(9) < 7) begin
      x = $urandom_range(7) + (($urandom_range(1) != 0) ? 56 : 0);
      z = $urandom_range(7) + (($urandom_range(1) != 0) ? 56 : 0);
    end else begin
      x = $urandom_range(63);
      z = $urandom_range(63);
    end
    lvl = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(6);
    if (r < 50) return mk_in(CMD_SET, x, z, lvl, $urandom_range(1), $urandom_range(63));
    if (r < 80) return mk_in(CMD_PROC, x, z, lvl, $urandom_range(1), $urandom_range(63));
    if (r < 98) return mk_in(CMD_QUERY, x, z, lvl, $urandom_range(1), $urandom_range(63));
    return mk_in(CMD_CLEAR, x, z, lvl, $urandom_range(1), $urandom_range(63));
  endfunction

  // sends one word, holding valid until accepted
  task automatic send_word(in_word_t w, bit typed, out_word_t e);
    out_word_t res [$];
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
    propagate(w, res);
    if (typed) expected_q.push_back(e);
    else foreach (res[i]) expected_q.push_back(res[i]);
    words_sent++;
    calm = (words_sent >= 60 && words_sent < 130);
    if (words_sent == 150) hold_go = 1'b1;
    // random gaps between words, none inside the calm window
    if (!calm && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // stimulus
  initial begin
    errors = 0;
    words_sent = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    wipe_grid();
    build_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[i]) send_word(table_rows[i].word, table_rows[i].typed,
                                      table_rows[i].exp);
    for (int i = 0; i < N_RANDOM; i++) send_word(rand_word(), 1'b0, '0);
    in_if.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end
      out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_if.data, '0);
      end else begin
        e = expected_q.pop_front();
        if (out_if.data.kind !== e.kind || out_if.data.cell_x !== e.cell_x ||
            out_if.data.cell_z !== e.cell_z || out_if.data.old_level !== e.old_level ||
            out_if.data.new_level !== e.new_level ||
            out_if.data.source_level !== e.source_level ||
            out_if.data.processed !== e.processed ||
            out_if.data.queue_empty !== e.queue_empty || out_if.data.last !== e.last)
          report_mismatch("field", out_if.data, e);
      end
    end
  end

  // watchdog on cycles with no handshake on either side, and the final verdict
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (stim_done) begin
      if (errors == 0 && expected_q.size() == 0)
        $display("grid_distance_level_propagator_unit verification clean");
      else
        $display("grid_distance_level_propagator_unit verification failed");
      $finish;
    end else if (quiet_cycles > IDLE_LIMIT) begin
      $display("timeout, %0d words outstanding", expected_q.size());
      $display("grid_distance_level_propagator_unit verification failed");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
